>>> design/mpcr_pkg.sv
// ----------------------------------------------------------------------------
// Meter password challenge-response: shared package
// Sequencer states, status struct, ASCII hex conversion helpers.
// ----------------------------------------------------------------------------
package mpcr_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned NIB_W    = 4;
    localparam int unsigned N_BYTES  = 8;
    localparam int unsigned IDX_W    = 3;
    localparam int unsigned CNT_W    = 4;
    localparam int unsigned PW_W     = N_BYTES * BYTE_W;

    localparam logic [PW_W-1:0]  PW_RESET  = 64'h3030_3030_3030_3030;
    localparam logic [CNT_W-1:0] LAST_POS  = 4'hF;
    localparam logic [IDX_W-1:0] LAST_IDX  = 3'd7;

    localparam logic [BYTE_W-1:0] ASCII_0 = 8'h30;
    localparam logic [BYTE_W-1:0] ASCII_9 = 8'h39;
    localparam logic [BYTE_W-1:0] ASCII_A = 8'h41;
    localparam logic [BYTE_W-1:0] ASCII_F = 8'h46;

    // Response sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_SEED,
        S_HIGH,
        S_LOW
    } t_seq_state;

    // Status from the response unit back to the input side
    typedef struct packed {
        logic             busy;
        logic [IDX_W-1:0] rd_idx;
    } t_resp_stat;

    // ASCII hex digit to nibble; anything outside 0-9 and A-F gives zero
    function automatic logic [NIB_W-1:0] hex_value(input logic [BYTE_W-1:0] c);
        logic [BYTE_W-1:0] d;
        d = '0;
        if (c >= ASCII_0 && c <= ASCII_9) begin
            d = c - ASCII_0;
        end else if (c >= ASCII_A && c <= ASCII_F) begin
            d = c - ASCII_A + 8'd10;
        end
        return d[NIB_W-1:0];
    endfunction

    // Nibble to uppercase ASCII hex digit
    function automatic logic [BYTE_W-1:0] hex_char(input logic [NIB_W-1:0] n);
        logic [BYTE_W-1:0] c;
        if (n <= 4'd9) begin
            c = ASCII_0 + {4'd0, n};
        end else begin
            c = ASCII_A + {4'd0, n} - 8'd10;
        end
        return c;
    endfunction

endpackage

>>> design/mpcr_resp_unit.sv
// ----------------------------------------------------------------------------
// Meter password challenge-response: response unit
// Runs one shared 8-bit adder over the eight mixed bytes and emits two hex
// characters per byte through a registered output stage.
// ----------------------------------------------------------------------------
module mpcr_resp_unit
    import mpcr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [BYTE_W-1:0] i_rd_data,
    output t_resp_stat        o_stat,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [BYTE_W-1:0] o_char,
    output logic              o_last
);

    t_seq_state        r_state, n_state;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic [BYTE_W-1:0] r_prev, n_prev;
    logic [BYTE_W-1:0] r_sum, n_sum;
    logic              r_valid, n_valid;
    logic [BYTE_W-1:0] r_char, n_char;
    logic              r_last, n_last;

    logic              out_free;
    logic [BYTE_W-1:0] add_out;

    // Shared adder: mixed byte plus previous result, wraps mod 256
    assign add_out  = i_rd_data + r_prev;
    assign out_free = !r_valid || i_ready;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_start) n_state = S_SEED;
            end
            S_SEED: n_state = S_HIGH;
            S_HIGH: begin
                if (out_free) n_state = S_LOW;
            end
            S_LOW: begin
                if (out_free) n_state = (r_idx == LAST_IDX) ? S_IDLE : S_HIGH;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath and output stage
    always_comb begin
        n_idx   = r_idx;
        n_prev  = r_prev;
        n_sum   = r_sum;
        n_valid = r_valid && !i_ready;
        n_char  = r_char;
        n_last  = r_last;
        case (r_state)
            S_SEED: begin
                n_prev = i_rd_data;
                n_idx  = '0;
            end
            S_HIGH: begin
                if (out_free) begin
                    n_sum   = add_out;
                    n_valid = 1'b1;
                    n_char  = hex_char(add_out[BYTE_W-1:NIB_W]);
                    n_last  = 1'b0;
                end
            end
            S_LOW: begin
                if (out_free) begin
                    n_prev  = r_sum;
                    n_idx   = r_idx + 1'b1;
                    n_valid = 1'b1;
                    n_char  = hex_char(r_sum[NIB_W-1:0]);
                    n_last  = (r_idx == LAST_IDX);
                end
            end
            default: begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_idx   <= n_idx;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_prev <= n_prev;
        r_sum  <= n_sum;
        r_char <= n_char;
        r_last <= n_last;
    end

    // Seed reads the last mixed byte, then walk from byte zero
    assign o_stat.busy   = (r_state != S_IDLE);
    assign o_stat.rd_idx = (r_state == S_SEED) ? LAST_IDX : r_idx;
    assign o_valid       = r_valid;
    assign o_char        = r_char;
    assign o_last        = r_last;

    a_start_seed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_start) |=> (r_state == S_SEED))
        else $error("start did not enter seed state");

    a_seed_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEED) |=> (r_state == S_HIGH && r_idx == '0))
        else $error("walk did not begin at byte zero");

    a_low_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOW && out_free) |=> (r_valid && r_char == hex_char($past(r_sum[NIB_W-1:0]))))
        else $error("low nibble character not presented");

    a_last_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOW && out_free && r_idx == LAST_IDX) |=> (r_state == S_IDLE && r_last))
        else $error("final character not flagged");

endmodule

>>> design/meter_password_challenge_response.sv
// ----------------------------------------------------------------------------
// Meter password challenge-response: top level
// Collects the 16-character hex challenge, mixes it with the password and
// streams out the 16-character response.
// ----------------------------------------------------------------------------
// Challenge characters are taken one per cycle while the block is idle. The
// sixteenth character starts the response walk: a seed step, then a high and
// a low step per response byte on the shared 8-bit adder, and the input stays
// stalled (s_axis_tready low) until the last character is registered.
// tuser on the input marks the first character of a challenge.
module meter_password_challenge_response
    import mpcr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [PW_W-1:0]   i_cfg_wdata,   // password byte i at bits 8i+7..8i
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [BYTE_W-1:0] s_axis_tdata,  // [7:0] challenge_char
    input  logic              s_axis_tuser,  // [0] first_char
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [BYTE_W-1:0] m_axis_tdata,  // [7:0] response_char
    output logic              m_axis_tlast
);

    logic [PW_W-1:0]   r_password;
    logic [CNT_W-1:0]  r_char_count;
    logic [NIB_W-1:0]  r_high_nibble;
    logic [BYTE_W-1:0] r_mixed [N_BYTES];

    t_resp_stat        stat;
    logic              accept;
    logic [CNT_W-1:0]  pos;
    logic [IDX_W-1:0]  wr_idx;
    logic [NIB_W-1:0]  nib;
    logic [BYTE_W-1:0] pw_byte;
    logic              start;

    assign s_axis_tready = !stat.busy;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign pos           = s_axis_tuser ? '0 : r_char_count;
    assign wr_idx        = pos[CNT_W-1:1];
    assign nib           = hex_value(s_axis_tdata);
    assign pw_byte       = r_password[wr_idx*BYTE_W +: BYTE_W];
    assign start         = accept && (pos == LAST_POS);

    // Hold password register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_password <= PW_RESET;
        end else if (i_cfg_we) begin
            r_password <= i_cfg_wdata;
        end
    end

    // Advance character position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_char_count  <= '0;
            r_high_nibble <= '0;
        end else if (accept) begin
            r_char_count <= pos + 1'b1;
            if (!pos[0]) r_high_nibble <= nib;
        end
    end

    // Store mixed byte on the second character of each pair
    always_ff @(posedge i_clk) begin
        if (accept && pos[0]) begin
            r_mixed[wr_idx] <= {r_high_nibble, nib} ^ pw_byte;
        end
    end

    mpcr_resp_unit u_resp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_rd_data (r_mixed[stat.rd_idx]),
        .o_stat    (stat),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_char    (m_axis_tdata),
        .o_last    (m_axis_tlast)
    );

    a_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |=> (r_char_count == '0 && stat.busy))
        else $error("count did not wrap after last challenge character");

    a_no_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.busy |-> !accept)
        else $error("item taken while response in progress");

    a_pair_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && pos[0]) |=> (r_mixed[$past(wr_idx)] ==
            ({$past(r_high_nibble), $past(nib)} ^ $past(pw_byte))))
        else $error("mixed byte not stored");

endmodule

>>> verif/tb_meter_password_challenge_response.sv
// ----------------------------------------------------------------------------
// Meter password challenge-response: self-checking testbench
// Streams hex challenges into the block, predicts each 16-character response
// from its own copy of the password, mixed bytes and character count, and
// checks every response item in order. Covers the reset password, all-zero,
// all-one and random passwords, invalid characters, restarts, broken
// challenges, a password change mid-challenge and a long sink stall.
// ----------------------------------------------------------------------------
module tb_meter_password_challenge_response;
    import mpcr_pkg::*;

    localparam int QUIET_LIMIT  = 3000;  // cycles without any handshake
    localparam int RX_LONG_HOLD = 300;   // long sink hold-off, in cycles
    localparam int SETTLE       = 24;    // margin after the response walk
    localparam int PHASE_ITEMS  = 56;

    typedef struct {
        logic [BYTE_W-1:0] ch;
        logic              first;
    } t_chal_item;

    typedef struct {
        logic [BYTE_W-1:0] ch;
        logic              last;
    } t_resp_char;

    logic              i_clk;
    logic              i_rst_n   = 1'b0;
    logic              cfg_we    = 1'b0;
    logic [PW_W-1:0]   cfg_wdata = '0;
    logic              s_valid   = 1'b0;
    wire               s_ready;
    logic [BYTE_W-1:0] s_data    = '0;
    logic              s_user    = 1'b0;
    wire               m_valid;
    logic              m_ready   = 1'b0;
    wire  [BYTE_W-1:0] m_data;
    wire               m_last;

    // Challenge items waiting for the driver, responses waiting for the sink
    t_chal_item chal_backlog[$];
    t_resp_char resp_due[$];

    // Predictor state
    logic [PW_W-1:0]   pred_pw    = PW_RESET;
    logic [BYTE_W-1:0] pred_mixed [N_BYTES];
    logic [CNT_W-1:0]  pred_count = '0;
    logic [NIB_W-1:0]  pred_high  = '0;

    // Idle shaping, set per phase by the sequence
    int src_gap_max   = 7;
    int rx_gap_max    = 7;
    int src_wait      = 0;
    int rx_wait       = 0;
    int rx_long_reqs  = 0;
    int rx_long_taken = 0;
    int rx_long_left  = 0;

    int fault_count  = 0;
    int chars_taken  = 0;
    int resp_checked = 0;
    int pw_writes    = 0;
    int quiet_cycles = 0;
    int carry        = 0;

    meter_password_challenge_response uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_wdata   (cfg_wdata),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_ready),
        .s_axis_tdata  (s_data),   // [7:0] challenge_char
        .s_axis_tuser  (s_user),   // [0] first_char
        .m_axis_tvalid (m_valid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_data),   // [7:0] response_char
        .m_axis_tlast  (m_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // ASCII hex digit to its value, anything else reads as zero
    function automatic logic [NIB_W-1:0] nibble_of(input logic [BYTE_W-1:0] c);
        if (c >= ASCII_0 && c <= ASCII_9) begin
            return c[NIB_W-1:0];
        end
        if (c >= ASCII_A && c <= ASCII_F) begin
            return c[NIB_W-1:0] + 4'd9;
        end
        return '0;
    endfunction

    // Value to uppercase ASCII hex digit
    function automatic logic [BYTE_W-1:0] digit_of(input logic [NIB_W-1:0] n);
        if (n < 4'd10) begin
            return {4'h3, n};
        end
        return ASCII_A + BYTE_W'(n - 4'd10);
    endfunction

    // Mostly valid digits, the rest any byte at all
    function automatic logic [BYTE_W-1:0] rand_char();
        if ($urandom_range(0, 2) == 0) begin
            return BYTE_W'($urandom_range(0, 255));
        end
        return digit_of(NIB_W'($urandom_range(0, 15)));
    endfunction

    // Fold one accepted challenge item into the state; queue the response
    // when it completes the challenge
    task automatic absorb_char(input logic [BYTE_W-1:0] ch, input logic first);
        logic [NIB_W-1:0]  nib;
        logic [CNT_W-1:0]  pos;
        logic [IDX_W-1:0]  idx;
        logic [BYTE_W-1:0] acc;
        int                i;
        nib = nibble_of(ch);
        if (first) begin
            pred_count = '0;
        end
        pos = pred_count;
        if (!pos[0]) begin
            pred_high = nib;
        end else begin
            idx = pos[CNT_W-1:1];
            pred_mixed[idx] = {pred_high, nib} ^ pred_pw[BYTE_W*idx +: BYTE_W];
        end
        pred_count = pos + 1'b1;
        if (pos == LAST_POS) begin
            acc = pred_mixed[LAST_IDX];
            for (i = 0; i < N_BYTES; i++) begin
                acc = pred_mixed[i] + acc;
                resp_due.push_back('{ch: digit_of(acc[7:4]), last: 1'b0});
                resp_due.push_back('{ch: digit_of(acc[3:0]), last: (i == N_BYTES - 1)});
            end
        end
    endtask

    // Present queued challenge items, drawing a gap after each
    always @(posedge i_clk) begin : drive_chars
        t_chal_item nxt;
        logic       vld;
        if (!i_rst_n) begin
            s_valid <= 1'b0;
            src_wait = 0;
        end else begin
            vld = s_valid;
            if (s_valid && s_ready) begin
                absorb_char(s_data, s_user);
                chars_taken++;
                vld = 1'b0;
            end
            if (!vld) begin
                if (src_wait > 0) begin
                    src_wait--;
                end else if (chal_backlog.size() > 0) begin
                    nxt = chal_backlog.pop_front();
                    s_data <= nxt.ch;
                    s_user <= nxt.first;
                    src_wait = $urandom_range(0, src_gap_max);
                    vld = 1'b1;
                end
            end
            s_valid <= vld;
        end
    end

    // Check response items against the oldest expectation; shape tready
    always @(posedge i_clk) begin : check_resp
        t_resp_char want;
        logic       rdy;
        if (!i_rst_n) begin
            m_ready <= 1'b0;
            rx_wait = 0;
        end else begin
            if (m_valid && m_ready) begin
                resp_checked++;
                if (resp_due.size() == 0) begin
                    fault_count++;
                    if (fault_count <= 10) begin
                        $display("ERROR: unexpected response char %h last %b", m_data, m_last);
                    end
                end else begin
                    want = resp_due.pop_front();
                    if (m_data !== want.ch || m_last !== want.last) begin
                        fault_count++;
                        if (fault_count <= 10) begin
                            $display("ERROR: response char exp %h last %b, got %h last %b",
                                     want.ch, want.last, m_data, m_last);
                        end
                    end
                end
                rx_wait = $urandom_range(0, rx_gap_max);
            end
            if (rx_long_left > 0) begin
                rx_long_left--;
                rdy = 1'b0;
            end else if (rx_long_taken != rx_long_reqs) begin
                rx_long_taken++;
                rx_long_left = RX_LONG_HOLD - 1;
                rdy = 1'b0;
            end else if (rx_wait > 0) begin
                rx_wait--;
                rdy = 1'b0;
            end else begin
                rdy = 1'b1;
            end
            m_ready <= rdy;
        end
    end

    // Stop a hung run
    always @(posedge i_clk) begin : watchdog
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic queue_char(input logic [BYTE_W-1:0] ch, input logic first);
        chal_backlog.push_back('{ch: ch, first: first});
    endtask

    // Queue n random characters, optionally flagging the first as a restart
    task automatic push_chars(input int n, input logic lead_first);
        int i;
        for (i = 0; i < n; i++) begin
            queue_char(rand_char(), lead_first && (i == 0));
        end
    endtask

    // Mostly whole challenges, some cut short and restarted by the next
    task automatic queue_mix(input int n);
        int sent;
        int len;
        sent = 0;
        while (sent < n) begin
            len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 15) : 16;
            push_chars(len, 1'b1);
            sent += len;
        end
    endtask

    // Hold until the backlog is drained and every response is in
    task automatic wait_idle();
        while (chal_backlog.size() != 0 || s_valid || resp_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_password(input logic [PW_W-1:0] v);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        pred_pw = v;
        pw_writes++;
    endtask

    initial begin : sequence_run
        int               i;
        int               ph;
        logic [PW_W-1:0]  pw;
        for (i = 0; i < N_BYTES; i++) begin
            pred_mixed[i] = '0;
        end
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: all valid digits under the reset password
        for (i = 0; i < 16; i++) begin
            queue_char(digit_of(NIB_W'(i)), i == 0);
        end
        // Count wraps, so no restart flag; invalid characters, half a challenge
        queue_char(8'h00, 1'b0);
        queue_char(8'hFF, 1'b0);
        queue_char(8'h2F, 1'b0);
        queue_char(8'h3A, 1'b0);
        queue_char(8'h40, 1'b0);
        queue_char(8'h47, 1'b0);
        queue_char(8'h61, 1'b0);
        queue_char(8'h66, 1'b0);
        carry = 8;

        // Random phases, each under its own password and idle shape
        for (ph = 0; ph < 5; ph++) begin
            wait_idle();
            case (ph)
                0: pw = '1;
                1: pw = '0;
                default: pw = {$urandom, $urandom};
            endcase
            write_password(pw);
            src_gap_max = (ph % 2 == 1) ? 7 : 0;
            rx_gap_max  = (ph % 3 == 0) ? 0 : 7;
            if (ph == 2) begin
                rx_long_reqs++;
            end
            // Finish a challenge begun under the previous password
            if (carry > 0) begin
                push_chars(carry, 1'b0);
                carry = 0;
            end
            queue_mix(PHASE_ITEMS);
            if (ph == 3) begin
                push_chars(7, 1'b1);
                carry = 9;
            end
        end

        wait_idle();
        if (resp_due.size() != 0) begin
            fault_count++;
        end
        $display("summary: %0d challenge chars sent, %0d response chars checked, %0d faults",
                 chars_taken, resp_checked, fault_count);
        $display("summary: %0d password writes after reset value; restarts, invalid chars,",
                 pw_writes);
        $display("summary: mid-challenge password change and long sink stall exercised");
        if (fault_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
